>>> src/midi_note_message_parser_defines.svh
// ---------------------------------------------------------------------------
// MIDI note message parser assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef MIDI_NOTE_MESSAGE_PARSER_DEFINES_SVH
`define MIDI_NOTE_MESSAGE_PARSER_DEFINES_SVH

// Same-cycle implication check.
`define MNMP_ASSERT_IMP(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("mnmp same-cycle check failed");

// Next-cycle implication check.
`define MNMP_ASSERT_NXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("mnmp next-cycle check failed");

`endif

>>> src/mnmp_pkg.sv
// ---------------------------------------------------------------------------
// MIDI note message parser package
// Result kinds, MIDI command codes and the structs shared by the modules.
// ---------------------------------------------------------------------------
package mnmp_pkg;

   localparam int NOTE_BITS  = 7;
   localparam int NOTE_COUNT = 1 << NOTE_BITS;

   typedef enum logic [1:0] {
      KIND_ON    = 2'd0,
      KIND_OFF   = 2'd1,
      KIND_OTHER = 2'd2,
      KIND_QUERY = 2'd3
   } kind_type;

   typedef enum logic {
      OP_BYTE  = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   typedef enum logic {
      MAP_CLEAR = 1'b0,
      MAP_RUN   = 1'b1
   } map_state_type;

   // Command nibbles of the status byte.
   localparam logic [3:0] CMD_NOTE_OFF = 4'h8;
   localparam logic [3:0] CMD_NOTE_ON  = 4'h9;
   localparam logic [3:0] CMD_PROGRAM  = 4'hC;
   localparam logic [3:0] CMD_PRESSURE = 4'hD;

   localparam logic [6:0] VEL_DEFAULT = 7'd64;

   // Engine codes that bound dispatch.
   localparam logic [2:0] ENGINE_SYNTH   = 3'd2;
   localparam logic [2:0] ENGINE_SAMPLER = 3'd3;

   typedef struct packed {
      logic                 result;
      kind_type             kind;
      logic [3:0]           channel;
      logic [NOTE_BITS-1:0] note;
      logic [6:0]           velocity;
      logic                 dispatched;
      logic [2:0]           engine;
      logic                 active;
      logic                 use_map;
   } dec_type;

   typedef struct packed {
      logic                 wr_en;
      logic                 wr_data;
      logic                 rd_en;
      logic [NOTE_BITS-1:0] addr;
   } map_req_type;

endpackage

>>> src/midi_note_message_parser.sv
// ---------------------------------------------------------------------------
// MIDI note message parser
// Running-status MIDI decoder with an active-note map and engine dispatch.
// ---------------------------------------------------------------------------
// The block takes one request per clock cycle while req_tready is high,
// either a raw MIDI byte or a query of one note's active bit, and answers
// each complete message or query through stage 1 and the output register.
// Throughput is one request per cycle as long as results are taken; the
// 128 x 1 note map serves at most one access per request, which is what
// sets that rate. After reset the map is cleared by a pass that writes one
// entry per cycle, so req_tready stays low until the last entry is written;
// the configuration register may be written during that time. A status
// byte, and the first data byte of a two-byte message, produce no result.
// Note on sets the note's map bit and note off clears it. The target engine
// register is only to be written while no request is in flight.
// ---------------------------------------------------------------------------
`include "midi_note_message_parser_defines.svh"

module midi_note_message_parser
   import mnmp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Configuration.
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_wr_data,    // target_engine
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,      // [7:0] midi_byte, [14:8] query_note, [15] zero
   input  logic        req_tuser,      // [0] op
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,      // [3:0] channel, [10:4] note_number,
                                       // [17:11] velocity, [18] dispatched,
                                       // [21:19] engine, [22] note_active,
                                       // [23] zero
   output logic [1:0]  rsp_tuser       // [1:0] kind
);

   logic [2:0]  target_engine_ff;

   logic        accept;
   dec_type     dec;
   map_req_type map_req;
   logic        map_ready;
   logic        map_rd_data;

   // Stage 1 waits for the memory read; the output stage holds the result.
   logic        s1_valid_ff, s1_valid_in;
   dec_type     s1_ff;
   logic        s1_move;

   logic        rsp_valid_ff, rsp_valid_in;
   kind_type    rsp_kind_ff;
   logic [3:0]  rsp_channel_ff;
   logic [6:0]  rsp_note_ff;
   logic [6:0]  rsp_velocity_ff;
   logic        rsp_dispatched_ff;
   logic [2:0]  rsp_engine_ff;
   logic        rsp_active_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_engine_ff <= ENGINE_SYNTH;
      end else if (csr_wr_en) begin
         target_engine_ff <= csr_wr_data;
      end
   end

   // The output register frees up when empty or when its result is taken,
   // and stage 1 may then take a new request in the same cycle.
   assign s1_move    = !rsp_valid_ff || rsp_tready;
   assign req_tready = map_ready && (!s1_valid_ff || s1_move);
   assign accept     = req_tvalid && req_tready;

   mnmp_decode u_decode (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .op            (req_tuser),
      .midi_byte     (req_tdata[7:0]),
      .query_note    (req_tdata[14:8]),
      .target_engine (target_engine_ff),
      .dec           (dec),
      .map_req       (map_req)
   );

   map_req_type map_req_gated;

   always_comb begin
      map_req_gated       = map_req;
      map_req_gated.wr_en = map_req.wr_en && accept;
      map_req_gated.rd_en = map_req.rd_en && accept;
   end

   mnmp_note_map u_note_map (
      .clock     (clock),
      .reset     (reset),
      .map_req   (map_req_gated),
      .map_ready (map_ready),
      .rd_data   (map_rd_data)
   );

   always_comb begin
      if (accept) begin
         s1_valid_in = dec.result;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      rsp_valid_in = s1_move ? s1_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= dec;
      end
      if (s1_move && s1_valid_ff) begin
         rsp_kind_ff       <= s1_ff.kind;
         rsp_channel_ff    <= s1_ff.channel;
         rsp_note_ff       <= s1_ff.note;
         rsp_velocity_ff   <= s1_ff.velocity;
         rsp_dispatched_ff <= s1_ff.dispatched;
         rsp_engine_ff     <= s1_ff.engine;
         // Reads come back here; note on and note off already know the bit.
         rsp_active_ff     <= s1_ff.use_map ? map_rd_data : s1_ff.active;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = {1'b0, rsp_active_ff, rsp_engine_ff, rsp_dispatched_ff,
                        rsp_velocity_ff, rsp_note_ff, rsp_channel_ff};

   `MNMP_ASSERT_IMP(a_no_accept_in_clear, !map_ready, !req_tready)
   `MNMP_ASSERT_IMP(a_single_map_access, map_req_gated.wr_en, !map_req_gated.rd_en)
   `MNMP_ASSERT_NXT(a_s1_holds_on_stall, s1_valid_ff && !s1_move, s1_valid_ff && $stable(s1_ff))
   `MNMP_ASSERT_IMP(a_note_on_sets_bit, rsp_valid_ff && (rsp_kind_ff == KIND_ON), rsp_active_ff)
   `MNMP_ASSERT_IMP(a_query_zero_fields, rsp_valid_ff && (rsp_kind_ff == KIND_QUERY), (rsp_channel_ff == 4'd0) && (rsp_velocity_ff == 7'd0) && !rsp_dispatched_ff && (rsp_engine_ff == 3'd0))

endmodule

>>> src/mnmp_decode.sv
// ---------------------------------------------------------------------------
// MIDI note message parser decoder
// Running status tracking, message assembly, classification and map access.
// ---------------------------------------------------------------------------
module mnmp_decode
   import mnmp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic                 op,
   input  logic [7:0]           midi_byte,
   input  logic [NOTE_BITS-1:0] query_note,
   input  logic [2:0]           target_engine,
   output dec_type              dec,
   output map_req_type          map_req
);

   logic [7:0]           running_status_ff, running_status_in;
   logic                 data_count_ff, data_count_in;
   logic [NOTE_BITS-1:0] first_data_ff, first_data_in;

   logic [3:0]           cmd;
   logic                 one_byte;
   logic [NOTE_BITS-1:0] note;
   logic [6:0]           vel;
   logic                 is_on;
   logic                 is_off;

   assign cmd      = running_status_ff[7:4];
   assign one_byte = (cmd == CMD_PROGRAM) || (cmd == CMD_PRESSURE);
   assign note     = data_count_ff ? first_data_ff : midi_byte[6:0];
   assign vel      = data_count_ff ? midi_byte[6:0] : VEL_DEFAULT;
   assign is_on    = (cmd == CMD_NOTE_ON) && (vel != 7'd0);
   assign is_off   = (cmd == CMD_NOTE_OFF) || ((cmd == CMD_NOTE_ON) && (vel == 7'd0));

   always_comb begin
      running_status_in = running_status_ff;
      data_count_in     = data_count_ff;
      first_data_in     = first_data_ff;
      dec               = '0;
      dec.kind          = KIND_OTHER;
      map_req           = '0;

      if (op == OP_QUERY) begin
         dec.result     = 1'b1;
         dec.kind       = KIND_QUERY;
         dec.note       = query_note;
         dec.use_map    = 1'b1;
         map_req.rd_en  = 1'b1;
         map_req.addr   = query_note;
      end else if (midi_byte[7]) begin
         running_status_in = midi_byte;
         data_count_in     = 1'b0;
      end else if (!data_count_ff && !one_byte) begin
         first_data_in = midi_byte[6:0];
         data_count_in = 1'b1;
      end else begin
         // The message is complete with this byte.
         data_count_in  = 1'b0;
         if (!data_count_ff) begin
            first_data_in = midi_byte[6:0];
         end
         dec.result     = 1'b1;
         dec.channel    = running_status_ff[3:0];
         dec.note       = note;
         dec.velocity   = vel;
         dec.engine     = target_engine;
         map_req.addr   = note;
         if (is_on) begin
            dec.kind        = KIND_ON;
            dec.dispatched  = (target_engine <= ENGINE_SYNTH);
            dec.active      = 1'b1;
            map_req.wr_en   = 1'b1;
            map_req.wr_data = 1'b1;
         end else if (is_off) begin
            dec.kind        = KIND_OFF;
            dec.dispatched  = (target_engine <= ENGINE_SAMPLER);
            dec.active      = 1'b0;
            map_req.wr_en   = 1'b1;
            map_req.wr_data = 1'b0;
         end else begin
            dec.kind      = KIND_OTHER;
            dec.use_map   = 1'b1;
            map_req.rd_en = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_status_ff <= '0;
         data_count_ff     <= 1'b0;
         first_data_ff     <= '0;
      end else if (accept) begin
         running_status_ff <= running_status_in;
         data_count_ff     <= data_count_in;
         first_data_ff     <= first_data_in;
      end
   end

endmodule

>>> src/mnmp_note_map.sv
// ---------------------------------------------------------------------------
// MIDI note message parser active-note map
// 128 x 1 synchronous memory with a clearing pass after reset.
// ---------------------------------------------------------------------------
module mnmp_note_map
   import mnmp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  map_req_type map_req,
   output logic        map_ready,
   output logic        rd_data
);

   map_state_type        state_ff, state_in;
   logic [NOTE_BITS-1:0] clr_addr_ff, clr_addr_in;
   logic                 rd_data_ff;
   logic                 mem [NOTE_COUNT];

   logic                 wr_en;
   logic                 wr_data;
   logic [NOTE_BITS-1:0] wr_addr;

   // Next state: leave the clearing pass after the last entry.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         MAP_CLEAR: begin
            if (clr_addr_ff == NOTE_BITS'(NOTE_COUNT - 1)) begin
               state_in = MAP_RUN;
            end
         end
         MAP_RUN: state_in = MAP_RUN;
         default: state_in = MAP_CLEAR;
      endcase
   end

   // Outputs of the state machine: write port source and ready.
   always_comb begin
      clr_addr_in = clr_addr_ff;
      map_ready   = 1'b0;
      wr_en       = map_req.wr_en;
      wr_data     = map_req.wr_data;
      wr_addr     = map_req.addr;
      case (state_ff)
         MAP_CLEAR: begin
            clr_addr_in = clr_addr_ff + NOTE_BITS'(1);
            wr_en       = 1'b1;
            wr_data     = 1'b0;
            wr_addr     = clr_addr_ff;
         end
         MAP_RUN: map_ready = 1'b1;
         default: map_ready = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= MAP_CLEAR;
         clr_addr_ff <= '0;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // At most one access per request, so a read never meets a write to the
   // same entry in one cycle; an earlier write has landed before a later read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (map_req.rd_en) begin
         rd_data_ff <= mem[map_req.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> test/midi_note_message_parser_tb.sv
// ---------------------------------------------------------------------------
// MIDI note message parser testbench
// Streams MIDI bytes and note queries into the parser under several engine
// settings and checks every result against a running-status predictor.
// ---------------------------------------------------------------------------
module midi_note_message_parser_tb;
   import mnmp_pkg::*;

   // Command nibbles and engine codes that the package does not name.
   localparam logic [3:0] CMD_POLY_TOUCH = 4'hA;
   localparam logic [3:0] CMD_CONTROL    = 4'hB;
   localparam logic [3:0] CMD_PITCH      = 4'hE;
   localparam logic [3:0] CMD_SYSTEM     = 4'hF;

   localparam logic [2:0] ENG_808    = 3'd0;
   localparam logic [2:0] ENG_CODE1  = 3'd1;
   localparam logic [2:0] ENG_FX     = 3'd4;
   localparam logic [2:0] ENG_CODE5  = 3'd5;
   localparam logic [2:0] ENG_SPARE6 = 3'd6;
   localparam logic [2:0] ENG_SPARE7 = 3'd7;

   localparam int unsigned PHASE_COUNT = 8;
   localparam int unsigned PHASE_ITEMS = 144;
   localparam int unsigned MAX_CYCLES  = 600_000;

   // One request as the driver presents it. A request flagged hold_for_drain
   // is not presented until every expected result has come back.
   typedef struct {
      op_type     op;
      logic [7:0] midi;
      logic [6:0] qnote;
      bit         hold_for_drain;
   } midi_request_type;

   // One result as the parser should produce it.
   typedef struct {
      kind_type   kind;
      logic [3:0] channel;
      logic [6:0] note;
      logic [6:0] velocity;
      logic       dispatched;
      logic [2:0] engine;
      logic       active;
   } note_event_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        csr_wr_en   = 1'b0;
   logic [2:0]  csr_wr_data = ENGINE_SYNTH;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata   = '0;
   logic        req_tuser   = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [23:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   midi_request_type pending_q[$];
   note_event_type   note_event_q[$];

   int unsigned req_issued   = 0;
   int unsigned req_accepted = 0;
   int unsigned send_gap     = 0;
   int unsigned sink_stall   = 0;
   int unsigned fault_count  = 0;
   bit          steady       = 1'b0;

   // Engine settings walked through, one per random phase; both ends of the
   // three-bit range and the two codes without meaning are among them.
   logic [2:0] engine_plan [0:PHASE_COUNT-1] = '{ENG_808, ENG_CODE5, ENG_SPARE7,
      ENGINE_SAMPLER, ENG_SPARE6, ENG_CODE1, ENG_FX, ENGINE_SYNTH};

   // Predictor state: running status, whether the first of two data bytes
   // has been seen, the held first data byte, the note map and the engine.
   logic [7:0] cur_status;
   logic       data_pending;
   logic [6:0] held_note;
   logic       note_on_map [NOTE_COUNT];
   logic [2:0] engine_sel;

   midi_note_message_parser dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Gap length for either side: mostly none, sometimes a few cycles and
   // now and then a long pause. Steady phases run without any gaps.
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (steady || roll < 60) return 0;
      if (roll < 88) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Notes cluster on a small range so that note on, note off and queries
   // keep hitting the same map entries; the end notes show up as well.
   function automatic logic [6:0] pick_note();
      int unsigned roll;
      roll = $urandom_range(0, 9);
      if (roll < 6) return 7'($urandom_range(60, 67));
      if (roll == 6) return 7'd0;
      if (roll == 7) return 7'd127;
      return 7'($urandom_range(0, 127));
   endfunction

   // The field a request does not use carries random bits.
   function automatic void push_byte(input logic [7:0] value);
      midi_request_type r;
      r.op             = OP_BYTE;
      r.midi           = value;
      r.qnote          = 7'($urandom);
      r.hold_for_drain = ($urandom_range(0, 199) == 0);
      pending_q.push_back(r);
   endfunction

   function automatic void push_query(input logic [6:0] note);
      midi_request_type r;
      r.op             = OP_QUERY;
      r.midi           = 8'($urandom);
      r.qnote          = note;
      r.hold_for_drain = ($urandom_range(0, 199) == 0);
      pending_q.push_back(r);
   endfunction

   function automatic void push_status(input logic [3:0] cmd, input logic [3:0] ch);
      push_byte({cmd, ch});
   endfunction

   function automatic void push_data(input logic [6:0] value);
      push_byte({1'b0, value});
   endfunction

   // Running-status decoder. Updates the predictor state for one accepted
   // request and queues the result that it causes, if any.
   function automatic void decode_midi_request(input op_type op, input logic [7:0] midi,
                                               input logic [6:0] qnote);
      note_event_type ev;
      logic [3:0]     cmd;
      logic [6:0]     vel;
      logic           single;
      if (op == OP_QUERY) begin
         // A query reads the map and leaves all state alone.
         ev.kind       = KIND_QUERY;
         ev.channel    = '0;
         ev.note       = qnote;
         ev.velocity   = '0;
         ev.dispatched = 1'b0;
         ev.engine     = '0;
         ev.active     = note_on_map[qnote];
         note_event_q.push_back(ev);
         return;
      end
      if (midi[7]) begin
         // Any status byte, system bytes included, restarts the message.
         cur_status   = midi;
         data_pending = 1'b0;
         return;
      end
      cmd    = cur_status[7:4];
      single = (cmd == CMD_PROGRAM) || (cmd == CMD_PRESSURE);
      if (!data_pending) begin
         held_note = midi[6:0];
         if (!single) begin
            data_pending = 1'b1;
            return;
         end
         vel = VEL_DEFAULT;
      end else begin
         vel = midi[6:0];
      end
      data_pending = 1'b0;
      if (cmd == CMD_NOTE_ON && vel != 7'd0) begin
         ev.kind                = KIND_ON;
         note_on_map[held_note] = 1'b1;
         ev.dispatched          = (engine_sel <= ENGINE_SYNTH);
      end else if (cmd == CMD_NOTE_OFF || cmd == CMD_NOTE_ON) begin
         // Note on with velocity zero is a note off.
         ev.kind                = KIND_OFF;
         note_on_map[held_note] = 1'b0;
         ev.dispatched          = (engine_sel <= ENGINE_SAMPLER);
      end else begin
         ev.kind       = KIND_OTHER;
         ev.dispatched = 1'b0;
      end
      ev.channel  = cur_status[3:0];
      ev.note     = held_note;
      ev.velocity = vel;
      ev.engine   = engine_sel;
      ev.active   = note_on_map[held_note];
      note_event_q.push_back(ev);
   endfunction

   function automatic string event_text(input note_event_type e);
      return $sformatf("kind %0d ch %0d note %0d vel %0d disp %0b eng %0d act %0b",
                       e.kind, e.channel, e.note, e.velocity, e.dispatched, e.engine,
                       e.active);
   endfunction

   // Request driver. It holds a presented request until the monitor has
   // seen it accepted, then waits out a random gap before the next one.
   // tvalid gets exactly one nonblocking assignment per falling edge.
   always @(negedge clock) begin : request_driver
      midi_request_type item;
      logic             drive;
      drive = 1'b0;
      if (reset) begin
         drive = 1'b0;
      end else if (req_tvalid && req_accepted != req_issued) begin
         drive = 1'b1;
      end else if (send_gap != 0) begin
         send_gap--;
      end else if (pending_q.size() != 0 &&
                   !(pending_q[0].hold_for_drain && note_event_q.size() != 0)) begin
         item = pending_q.pop_front();
         req_tuser <= item.op;
         req_tdata <= {1'b0, item.qnote, item.midi};
         req_issued++;
         send_gap = pick_gap();
         drive    = 1'b1;
      end
      req_tvalid <= drive;
   end

   // Result sink. Ready drops for a random number of cycles at a time.
   always @(negedge clock) begin : result_sink
      if (reset || sink_stall == 0) begin
         rsp_tready <= 1'b1;
         if (!reset) sink_stall = pick_gap();
      end else begin
         rsp_tready <= 1'b0;
         sink_stall--;
      end
   end

   // Monitor. At each rising edge it tracks engine writes, checks a taken
   // result against the oldest expectation, and runs accepted requests
   // through the predictor.
   always @(posedge clock) begin : result_monitor
      note_event_type got;
      note_event_type want;
      if (!reset) begin
         if (csr_wr_en) engine_sel = csr_wr_data;
         if (rsp_tvalid && rsp_tready) begin
            got.kind       = kind_type'(rsp_tuser);
            got.channel    = rsp_tdata[3:0];
            got.note       = rsp_tdata[10:4];
            got.velocity   = rsp_tdata[17:11];
            got.dispatched = rsp_tdata[18];
            got.engine     = rsp_tdata[21:19];
            got.active     = rsp_tdata[22];
            if (note_event_q.size() == 0) begin
               fault_count++;
               if (fault_count <= 10)
                  $display("%0t: result with none expected: %s", $time, event_text(got));
            end else begin
               want = note_event_q.pop_front();
               if (got.kind !== want.kind || got.channel !== want.channel ||
                   got.note !== want.note || got.velocity !== want.velocity ||
                   got.dispatched !== want.dispatched || got.engine !== want.engine ||
                   got.active !== want.active) begin
                  fault_count++;
                  if (fault_count <= 10) begin
                     $display("%0t: result mismatch", $time);
                     $display("   expected %s", event_text(want));
                     $display("   actual   %s", event_text(got));
                  end
               end
            end
         end
         if (req_tvalid && req_tready) begin
            decode_midi_request(op_type'(req_tuser), req_tdata[7:0], req_tdata[14:8]);
            req_accepted++;
         end
      end
   end

   // Waits on falling edges until every request has been taken and every
   // result has come back, then lets the pipeline empty of requests that
   // produce no result (status bytes and first data bytes).
   task automatic wait_idle();
      while (pending_q.size() != 0 || req_accepted != req_issued ||
             note_event_q.size() != 0)
         @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   task automatic queue_random_traffic(input int unsigned count);
      int unsigned made;
      logic [3:0]  cmd;
      made = 0;
      while (made < count) begin
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13: begin
               // A well-formed run: a status byte and one to three
               // messages under running status, queries mixed in.
               case ($urandom_range(0, 9))
                  0, 1, 2, 3: cmd = CMD_NOTE_ON;
                  4, 5:       cmd = CMD_NOTE_OFF;
                  6:          cmd = CMD_PROGRAM;
                  7:          cmd = CMD_PRESSURE;
                  8:          cmd = $urandom_range(0, 1) ? CMD_CONTROL : CMD_POLY_TOUCH;
                  default:    cmd = $urandom_range(0, 1) ? CMD_PITCH : CMD_SYSTEM;
               endcase
               push_status(cmd, 4'($urandom_range(0, 15)));
               made++;
               repeat ($urandom_range(1, 3)) begin
                  if ($urandom_range(0, 4) == 0) begin
                     push_query(pick_note());
                     made++;
                  end
                  push_data(pick_note());
                  made++;
                  if (cmd != CMD_PROGRAM && cmd != CMD_PRESSURE) begin
                     push_data(($urandom_range(0, 4) == 0) ?
                               7'd0 : 7'($urandom_range(1, 127)));
                     made++;
                  end
               end
            end
            14, 15, 16: begin
               push_query(pick_note());
               made++;
            end
            default: begin
               // Noise: any byte at all, which also breaks messages apart.
               push_byte(8'($urandom));
               made++;
            end
         endcase
      end
   endtask

   // Stimulus. Reset, a directed run under the reset engine, then one
   // random phase per engine setting. Engine writes happen only with the
   // parser idle; the drain before each one is also where the sender
   // pauses until every expected result is back.
   initial begin
      cur_status   = '0;
      data_pending = 1'b0;
      held_note    = '0;
      engine_sel   = ENGINE_SYNTH;
      foreach (note_on_map[i]) note_on_map[i] = 1'b0;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Data bytes before any status byte form an "other" message on
      // channel 0.
      push_data(7'd60);
      push_data(7'd64);
      push_query(7'd127);
      // Note on at both ends of the note and velocity ranges, the second
      // one under running status.
      push_status(CMD_NOTE_ON, 4'd0);
      push_data(7'd0);
      push_data(7'd127);
      push_data(7'd127);
      push_data(7'd1);
      // Note on with velocity zero turns note 127 off again.
      push_status(CMD_NOTE_ON, 4'd15);
      push_data(7'd127);
      push_data(7'd0);
      push_query(7'd127);
      push_query(7'd0);
      push_status(CMD_NOTE_OFF, 4'd10);
      push_data(7'd0);
      push_data(7'd64);
      // One-data-byte messages take the default velocity.
      push_status(CMD_PROGRAM, 4'd5);
      push_data(7'd18);
      push_status(CMD_PRESSURE, 4'd15);
      push_data(7'd127);
      push_status(CMD_CONTROL, 4'd3);
      push_data(7'd7);
      push_data(7'd100);
      // A system byte in the middle of a note on drops the half message
      // and becomes the running status itself.
      push_status(CMD_NOTE_ON, 4'd1);
      push_data(7'd48);
      push_status(CMD_SYSTEM, 4'd8);
      push_data(7'd49);
      push_data(7'd50);
      wait_idle();

      for (int unsigned phase = 0; phase < PHASE_COUNT; phase++) begin
         csr_wr_en   <= 1'b1;
         csr_wr_data <= engine_plan[phase];
         @(negedge clock);
         csr_wr_en   <= 1'b0;
         steady = (phase == 2 || phase == 5);
         queue_random_traffic(PHASE_ITEMS);
         wait_idle();
      end

      if (fault_count == 0 && note_event_q.size() == 0) begin
         $display("midi_note_message_parser_tb OK");
      end else begin
         $display("midi_note_message_parser_tb NOT OK");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest correct run including the map
   // clearing pass after reset.
   initial begin
      #(12 * MAX_CYCLES);
      $display("timeout with %0d results outstanding", note_event_q.size());
      $display("midi_note_message_parser_tb NOT OK");
      $finish;
   end

endmodule

>>> sim.f
+incdir+src
src/mnmp_pkg.sv
src/mnmp_decode.sv
src/mnmp_note_map.sv
src/midi_note_message_parser.sv
test/midi_note_message_parser_tb.sv
